// ----- rtl/averaged_bearing_deadband_drive_macros.svh -----
// ---------------------------------------------------------------------------
// Averaged bearing dead-band drive: assertion macros
// Shared concurrent assertion forms, clocked on clock and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef AVERAGED_BEARING_DEADBAND_DRIVE_MACROS_SVH
`define AVERAGED_BEARING_DEADBAND_DRIVE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ABDD_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ABDD_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/abdd_pkg.sv -----
// ---------------------------------------------------------------------------
// Averaged bearing dead-band drive: package
// Field widths, register codes, reset values, sequencer states and the
// CORDIC arctangent table.
// ---------------------------------------------------------------------------
package abdd_pkg;

   // Word field widths.
   localparam int POS_W    = 16;
   localparam int ORIENT_W = 16;
   localparam int ANGLE_W  = 18;
   localparam int VEL_W    = 16;
   localparam int GOAL_W   = 18;
   localparam int DBAND_W  = 16;
   localparam int GAIN_W   = 20;
   localparam int SPEED_W  = 15;
   localparam int SUM_W    = 28;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 20;

   // Default parameter values and limits.
   localparam int SAMPLES_PER_DECISION_DEF = 3;
   localparam int ARCTAN_ITERATIONS_DEF    = 16;
   localparam int ATAN_TABLE_LEN           = 24;

   // Fixed-point constants.
   localparam int HALF_PI_Q16 = 102944;
   localparam int SUM_MAX     = 134217727;
   localparam int SUM_MIN     = -134217728;

   // Register reset values.
   localparam int GOAL_RESET  = 0;
   localparam int DBAND_RESET = 197;
   localparam int GAIN_RESET  = 166038;
   localparam int SPEED_RESET = 19661;

   // Configuration register indexes.
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_GOAL_ANGLE       = 2'd0,
      REG_DEADBAND         = 2'd1,
      REG_ORIENTATION_GAIN = 2'd2,
      REG_DRIVE_SPEED      = 2'd3
   } csr_reg_type;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROTATE,
      ST_BEAR,
      ST_ACCUM,
      ST_DECIDE,
      ST_RESULT
   } state_type;

   // atan(2^-i) in radians, 16 fraction bits; zero past the table's useful end.
   function automatic logic [15:0] atan_entry(input logic [4:0] idx);
      logic [15:0] val;
      unique case (idx)
         5'd0:  val = 16'd51472;
         5'd1:  val = 16'd30385;
         5'd2:  val = 16'd16055;
         5'd3:  val = 16'd8150;
         5'd4:  val = 16'd4091;
         5'd5:  val = 16'd2047;
         5'd6:  val = 16'd1024;
         5'd7:  val = 16'd512;
         5'd8:  val = 16'd256;
         5'd9:  val = 16'd128;
         5'd10: val = 16'd64;
         5'd11: val = 16'd32;
         5'd12: val = 16'd16;
         5'd13: val = 16'd8;
         5'd14: val = 16'd4;
         5'd15: val = 16'd2;
         5'd16: val = 16'd1;
         default: val = 16'd0;
      endcase
      return val;
   endfunction

endpackage

// ----- rtl/abdd_req_if.sv -----
// ---------------------------------------------------------------------------
// Averaged bearing dead-band drive: request channel
// Valid/ready channel carrying one position and orientation sample.
// ---------------------------------------------------------------------------
interface abdd_req_if;
   logic                                      valid;
   logic                                      ready;
   logic                                      run;
   logic signed [abdd_pkg::POS_W-1:0]         pos_x;
   logic signed [abdd_pkg::POS_W-1:0]         pos_y;
   logic signed [abdd_pkg::ORIENT_W-1:0]      orient;

   modport source (output valid, run, pos_x, pos_y, orient, input ready);
   modport sink   (input valid, run, pos_x, pos_y, orient, output ready);
endinterface

// ----- rtl/abdd_rsp_if.sv -----
// ---------------------------------------------------------------------------
// Averaged bearing dead-band drive: response channel
// Valid/ready channel carrying the bearing and the drive decision.
// ---------------------------------------------------------------------------
interface abdd_rsp_if;
   logic                                      valid;
   logic                                      ready;
   logic signed [abdd_pkg::ANGLE_W-1:0]       bearing_angle;
   logic signed [abdd_pkg::VEL_W-1:0]         drive_velocity;
   logic                                      drive_updated;

   modport source (output valid, bearing_angle, drive_velocity, drive_updated,
                   input ready);
   modport sink   (input valid, bearing_angle, drive_velocity, drive_updated,
                   output ready);
endinterface

// ----- rtl/abdd_csr_if.sv -----
// ---------------------------------------------------------------------------
// Averaged bearing dead-band drive: register write channel
// Valid/ready channel carrying a register index and write data.
// ---------------------------------------------------------------------------
interface abdd_csr_if;
   logic                                      valid;
   logic                                      ready;
   logic [abdd_pkg::CSR_IDX_W-1:0]            index;
   logic [abdd_pkg::CSR_DATA_W-1:0]           wdata;

   modport source (output valid, index, wdata, input ready);
   modport sink   (input valid, index, wdata, output ready);
endinterface

// ----- rtl/averaged_bearing_deadband_drive.sv -----
// ---------------------------------------------------------------------------
// Averaged bearing dead-band drive
// Computes the target bearing with an iterative CORDIC, accumulates the
// angle error and issues a dead-band drive decision every few samples.
//
//   Channel  Port    Direction  Word
//   request  req_if  in         run, pos_x, pos_y, orient
//   response rsp_if  out        bearing_angle, drive_velocity, drive_updated
//   register csr_if  in         index, wdata (always ready)
//
// A running sample goes from accept through ROTATE, where the shared CORDIC step
// runs min(ARCTAN_ITERATIONS, 24) times, then BEAR, ACCUM and DECIDE to RESULT.
// A stopped sample (run low) gives its response in the cycle after accept.
// The request side stays not ready until the response word is taken and
// opens again in the cycle after that.
// Reset is synchronous; no clearing pass is needed after it.
// ---------------------------------------------------------------------------
module averaged_bearing_deadband_drive #(
   parameter int SAMPLES_PER_DECISION = abdd_pkg::SAMPLES_PER_DECISION_DEF,
   parameter int ARCTAN_ITERATIONS    = abdd_pkg::ARCTAN_ITERATIONS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   abdd_req_if.sink   req_if,
   abdd_rsp_if.source rsp_if,
   abdd_csr_if.sink   csr_if
);

   localparam int Iters = (ARCTAN_ITERATIONS < abdd_pkg::ATAN_TABLE_LEN) ?
                          ARCTAN_ITERATIONS : abdd_pkg::ATAN_TABLE_LEN;
   localparam int IterW = $clog2(Iters);
   localparam int CntW  = $clog2(SAMPLES_PER_DECISION + 1);
   localparam int XyW   = 40;
   localparam int ZW    = 19;
   localparam int ProdW = abdd_pkg::GAIN_W + 1 + abdd_pkg::ORIENT_W;
   localparam int ThW   = ProdW - 14;
   localparam int ErrW  = 25;
   localparam int AccW  = abdd_pkg::SUM_W + 1;
   localparam int LimW  = abdd_pkg::SUM_W;

   // Control state.
   abdd_pkg::state_type state_ff, state_in;
   logic [IterW-1:0]    iter_ff;
   logic [CntW-1:0]     count_ff;
   logic signed [abdd_pkg::SUM_W-1:0] sum_ff;

   // Configuration registers.
   logic signed [abdd_pkg::GOAL_W-1:0] goal_ff;
   logic [abdd_pkg::DBAND_W-1:0]       dband_ff;
   logic [abdd_pkg::GAIN_W-1:0]        gain_ff;
   logic [abdd_pkg::SPEED_W-1:0]       speed_ff;

   // Payload registers.
   logic signed [XyW-1:0]              x_ff, y_ff;
   logic signed [ZW-1:0]               z_ff;
   logic                               px_zero_ff;
   logic signed [abdd_pkg::POS_W-1:0]  py_ff;
   logic signed [abdd_pkg::ORIENT_W-1:0] orient_ff;
   logic signed [ProdW-1:0]            prod_ff;
   logic signed [abdd_pkg::ANGLE_W-1:0] bear_ff;
   logic signed [abdd_pkg::ANGLE_W-1:0] rsp_bear_ff;
   logic signed [abdd_pkg::VEL_W-1:0]  rsp_vel_ff;
   logic                               rsp_upd_ff;

   // Handshake strobes.
   logic req_acc, rsp_acc, csr_acc, rot_last;

   assign req_acc  = req_if.valid && req_if.ready;
   assign rsp_acc  = rsp_if.valid && rsp_if.ready;
   assign csr_acc  = csr_if.valid && csr_if.ready;
   assign rot_last = (iter_ff == IterW'(Iters - 1));

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         abdd_pkg::ST_IDLE: begin
            if (req_acc) begin
               state_in = req_if.run ? abdd_pkg::ST_ROTATE : abdd_pkg::ST_RESULT;
            end
         end
         abdd_pkg::ST_ROTATE: begin
            if (rot_last) begin
               state_in = abdd_pkg::ST_BEAR;
            end
         end
         abdd_pkg::ST_BEAR:   state_in = abdd_pkg::ST_ACCUM;
         abdd_pkg::ST_ACCUM:  state_in = abdd_pkg::ST_DECIDE;
         abdd_pkg::ST_DECIDE: state_in = abdd_pkg::ST_RESULT;
         abdd_pkg::ST_RESULT: begin
            if (rsp_acc) begin
               state_in = abdd_pkg::ST_IDLE;
            end
         end
         default: state_in = abdd_pkg::ST_IDLE;
      endcase
   end

   // Handshake outputs.
   always_comb begin
      req_if.ready          = (state_ff == abdd_pkg::ST_IDLE);
      rsp_if.valid          = (state_ff == abdd_pkg::ST_RESULT);
      csr_if.ready          = 1'b1;
      rsp_if.bearing_angle  = rsp_bear_ff;
      rsp_if.drive_velocity = rsp_vel_ff;
      rsp_if.drive_updated  = rsp_upd_ff;
   end

   // Input conditioning: reflect through the origin when x is negative.
   logic signed [abdd_pkg::POS_W:0] px_ext, py_ext, px_abs, py_ref;
   logic signed [XyW-1:0]           x_init, y_init;

   always_comb begin
      px_ext = {req_if.pos_x[abdd_pkg::POS_W-1], req_if.pos_x};
      py_ext = {req_if.pos_y[abdd_pkg::POS_W-1], req_if.pos_y};
      px_abs = req_if.pos_x[abdd_pkg::POS_W-1] ? -px_ext : px_ext;
      py_ref = req_if.pos_x[abdd_pkg::POS_W-1] ? -py_ext : py_ext;
      x_init = {{(XyW - abdd_pkg::POS_W - 21){px_abs[abdd_pkg::POS_W]}}, px_abs, 20'b0};
      y_init = {{(XyW - abdd_pkg::POS_W - 21){py_ref[abdd_pkg::POS_W]}}, py_ref, 20'b0};
   end

   // One CORDIC vectoring step, shared over all iterations.
   logic signed [XyW-1:0] dx, dy, x_step, y_step;
   logic signed [ZW-1:0]  atan_z, z_step;

   always_comb begin
      dx     = y_ff >>> iter_ff;
      dy     = x_ff >>> iter_ff;
      atan_z = $signed({3'b000, abdd_pkg::atan_entry(5'(iter_ff))});
      if (!y_ff[XyW-1]) begin
         x_step = x_ff + dx;
         y_step = y_ff - dy;
         z_step = z_ff + atan_z;
      end else begin
         x_step = x_ff - dx;
         y_step = y_ff + dy;
         z_step = z_ff - atan_z;
      end
   end

   // Bearing: axis cases first, otherwise the clamped CORDIC angle.
   logic signed [abdd_pkg::ANGLE_W-1:0] bear_w;

   always_comb begin
      priority if (px_zero_ff) begin
         if (py_ff > 0) begin
            bear_w = abdd_pkg::ANGLE_W'(abdd_pkg::HALF_PI_Q16);
         end else if (py_ff < 0) begin
            bear_w = -abdd_pkg::ANGLE_W'(abdd_pkg::HALF_PI_Q16);
         end else begin
            bear_w = '0;
         end
      end else if (z_ff > ZW'(abdd_pkg::HALF_PI_Q16)) begin
         bear_w = abdd_pkg::ANGLE_W'(abdd_pkg::HALF_PI_Q16);
      end else if (z_ff < -ZW'(abdd_pkg::HALF_PI_Q16)) begin
         bear_w = -abdd_pkg::ANGLE_W'(abdd_pkg::HALF_PI_Q16);
      end else begin
         bear_w = abdd_pkg::ANGLE_W'(z_ff);
      end
   end

   // Orientation scaling: the product is taken from registers and registered.
   logic signed [ProdW-1:0] prod_w;
   assign prod_w = ProdW'($signed({1'b0, gain_ff})) * ProdW'(orient_ff);

   // Angle error and saturating accumulate.
   logic signed [ThW-1:0]  theta_w;
   logic signed [ErrW-1:0] err_w;
   logic signed [AccW-1:0] acc_w;
   logic signed [abdd_pkg::SUM_W-1:0] sum_sat;

   always_comb begin
      theta_w = prod_ff[ProdW-1:14];
      err_w   = ErrW'(theta_w) - ErrW'(abdd_pkg::HALF_PI_Q16) + ErrW'(bear_ff);
      acc_w   = AccW'(sum_ff) + AccW'(err_w);
      priority if (acc_w > AccW'(abdd_pkg::SUM_MAX)) begin
         sum_sat = abdd_pkg::SUM_W'(abdd_pkg::SUM_MAX);
      end else if (acc_w < AccW'(abdd_pkg::SUM_MIN)) begin
         sum_sat = abdd_pkg::SUM_W'(abdd_pkg::SUM_MIN);
      end else begin
         sum_sat = acc_w[abdd_pkg::SUM_W-1:0];
      end
   end

   // Dead-band limits, scaled by the samples per decision.
   logic signed [abdd_pkg::GOAL_W:0] band_hi, band_lo;
   logic signed [LimW-1:0]           lim_hi, lim_lo;
   logic signed [abdd_pkg::VEL_W-1:0] speed_pos;

   always_comb begin
      band_hi   = (abdd_pkg::GOAL_W + 1)'(goal_ff) + $signed({3'b000, dband_ff});
      band_lo   = (abdd_pkg::GOAL_W + 1)'(goal_ff) - $signed({3'b000, dband_ff});
      lim_hi    = LimW'(band_hi) * LimW'(SAMPLES_PER_DECISION);
      lim_lo    = LimW'(band_lo) * LimW'(SAMPLES_PER_DECISION);
      speed_pos = $signed({1'b0, speed_ff});
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= abdd_pkg::ST_IDLE;
         iter_ff  <= '0;
         count_ff <= '0;
         sum_ff   <= '0;
         goal_ff  <= abdd_pkg::GOAL_W'(abdd_pkg::GOAL_RESET);
         dband_ff <= abdd_pkg::DBAND_W'(abdd_pkg::DBAND_RESET);
         gain_ff  <= abdd_pkg::GAIN_W'(abdd_pkg::GAIN_RESET);
         speed_ff <= abdd_pkg::SPEED_W'(abdd_pkg::SPEED_RESET);
      end else begin
         state_ff <= state_in;

         // Register writes.
         if (csr_acc) begin
            unique case (abdd_pkg::csr_reg_type'(csr_if.index))
               abdd_pkg::REG_GOAL_ANGLE:
                  goal_ff <= $signed(csr_if.wdata[abdd_pkg::GOAL_W-1:0]);
               abdd_pkg::REG_DEADBAND:
                  dband_ff <= csr_if.wdata[abdd_pkg::DBAND_W-1:0];
               abdd_pkg::REG_ORIENTATION_GAIN:
                  gain_ff <= csr_if.wdata[abdd_pkg::GAIN_W-1:0];
               abdd_pkg::REG_DRIVE_SPEED:
                  speed_ff <= csr_if.wdata[abdd_pkg::SPEED_W-1:0];
               default: ;
            endcase
         end

         // Iteration counter.
         if (req_acc) begin
            iter_ff <= '0;
         end else if (state_ff == abdd_pkg::ST_ROTATE) begin
            iter_ff <= iter_ff + IterW'(1);
         end

         // Running sum and sample count.
         if (req_acc && !req_if.run) begin
            sum_ff   <= '0;
            count_ff <= '0;
         end else if (state_ff == abdd_pkg::ST_ACCUM) begin
            sum_ff   <= sum_sat;
            count_ff <= count_ff + CntW'(1);
         end else if (state_ff == abdd_pkg::ST_DECIDE &&
                      count_ff == CntW'(SAMPLES_PER_DECISION)) begin
            sum_ff   <= '0;
            count_ff <= '0;
         end
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      prod_ff <= prod_w;

      if (req_acc) begin
         x_ff       <= x_init;
         y_ff       <= y_init;
         z_ff       <= '0;
         px_zero_ff <= (req_if.pos_x == '0);
         py_ff      <= req_if.pos_y;
         orient_ff  <= req_if.orient;
      end else if (state_ff == abdd_pkg::ST_ROTATE) begin
         x_ff <= x_step;
         y_ff <= y_step;
         z_ff <= z_step;
      end

      if (state_ff == abdd_pkg::ST_BEAR) begin
         bear_ff <= bear_w;
      end

      // Response word.
      if (req_acc && !req_if.run) begin
         rsp_bear_ff <= '0;
         rsp_vel_ff  <= '0;
         rsp_upd_ff  <= 1'b1;
      end else if (state_ff == abdd_pkg::ST_DECIDE) begin
         rsp_bear_ff <= bear_ff;
         if (count_ff == CntW'(SAMPLES_PER_DECISION)) begin
            rsp_upd_ff <= 1'b1;
            priority if (LimW'(sum_ff) > lim_hi) begin
               rsp_vel_ff <= speed_pos;
            end else if (LimW'(sum_ff) < lim_lo) begin
               rsp_vel_ff <= -speed_pos;
            end else begin
               rsp_vel_ff <= '0;
            end
         end else begin
            rsp_upd_ff <= 1'b0;
            rsp_vel_ff <= '0;
         end
      end
   end

endmodule

// ----- rtl/abdd_checker.sv -----
// ---------------------------------------------------------------------------
// Averaged bearing dead-band drive: port checker
// Watches the top level's channels and checks sequencing and result words.
// ---------------------------------------------------------------------------
`include "averaged_bearing_deadband_drive_macros.svh"

module abdd_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_valid,
   input logic                                  req_ready,
   input logic                                  rsp_valid,
   input logic                                  rsp_ready,
   input logic signed [abdd_pkg::ANGLE_W-1:0]   rsp_bearing_angle,
   input logic signed [abdd_pkg::VEL_W-1:0]     rsp_drive_velocity,
   input logic                                  rsp_drive_updated
);

   // A word that was just taken keeps the request side closed.
   `ABDD_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready, "request accepted while busy")

   // Only one word is in the block at a time.
   `ABDD_ASSERT_NOW(a_no_overlap, rsp_valid, !req_ready, "request open while a response waits")

   // Without a decision the velocity is zero.
   `ABDD_ASSERT_NOW(a_quiet_velocity, rsp_valid && !rsp_drive_updated, rsp_drive_velocity == '0, "velocity without a decision")

   // The bearing never leaves the half circle.
   `ABDD_ASSERT_NOW(a_bearing_range, rsp_valid, (rsp_bearing_angle <= 18'sd102944) && (rsp_bearing_angle >= -18'sd102944), "bearing out of range")

   // A stalled response holds its word.
   `ABDD_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_bearing_angle) && $stable(rsp_drive_velocity), "stalled response changed")

endmodule

bind averaged_bearing_deadband_drive abdd_checker u_abdd_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_if.valid),
   .req_ready          (req_if.ready),
   .rsp_valid          (rsp_if.valid),
   .rsp_ready          (rsp_if.ready),
   .rsp_bearing_angle  (rsp_if.bearing_angle),
   .rsp_drive_velocity (rsp_if.drive_velocity),
   .rsp_drive_updated  (rsp_if.drive_updated)
);
